// File: rtl/core/srd_pkg.sv
// srd_pkg: shared types and constants for the stick radial deadzone block.
// Word formats, controller command codes and status bundle. No dependencies.
package srd_pkg;

	localparam int APB_ADDR_W = 2;
	localparam int DZ_W       = 14;
	localparam logic [DZ_W-1:0] DZ_RESET = 14'd3277;
	localparam logic [APB_ADDR_W-1:0] ADDR_DEADZONE = '0;

	typedef struct packed {
		logic               stick_select;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
	} sample_word_t;

	typedef struct packed {
		logic signed [15:0] scaled_x;
		logic signed [15:0] scaled_y;
		logic               dir_left;
		logic               dir_right;
		logic               dir_up;
		logic               dir_down;
	} result_word_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_ROOT_STEP,
		OP_SCALE_INIT,
		OP_DIV_STEP,
		OP_COMP_X_INIT,
		OP_COMP_Y_INIT,
		OP_RESULT,
		OP_RESULT_ZERO
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/srd_ctrl.sv
// srd_ctrl: sequencer for the stick deadzone datapath.
// Steps the squares, the root and the three divisions. Uses srd_pkg.
module srd_ctrl #(
	parameter int FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	input  srd_pkg::status_t status,
	output srd_pkg::cmd_t    cmd
);
	import srd_pkg::*;

	localparam int NUM_W = (2*FRAC_BITS+1 > FRAC_BITS+16) ? 2*FRAC_BITS+1 : FRAC_BITS+16;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_ROOT,
		S_DECIDE,
		S_DIVS,
		S_COMPX,
		S_DIVX,
		S_COMPY,
		S_DIVY,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					state_q <= S_ROOT;
					cnt_q   <= CNT_W'(15);
				end
				S_ROOT: begin
					if (cnt_q == '0) state_q <= S_DECIDE;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_DECIDE: begin
					zero_q <= status.zero;
					cnt_q  <= CNT_W'(NUM_W - 1);
					state_q <= status.zero ? S_FINISH : S_DIVS;
				end
				S_DIVS: begin
					if (cnt_q == '0) state_q <= S_COMPX;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_COMPX: begin
					state_q <= S_DIVX;
					cnt_q   <= CNT_W'(NUM_W - 1);
				end
				S_DIVX: begin
					if (cnt_q == '0) state_q <= S_COMPY;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_COMPY: begin
					state_q <= S_DIVY;
					cnt_q   <= CNT_W'(NUM_W - 1);
				end
				S_DIVY: begin
					if (cnt_q == '0) state_q <= S_FINISH;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_FINISH: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:   if (sample_valid) cmd.op = OP_LOAD;
			S_SQX:    cmd.op = OP_SQX;
			S_SQY:    cmd.op = OP_SQY;
			S_ROOT:   cmd.op = OP_ROOT_STEP;
			S_DECIDE: if (!status.zero) cmd.op = OP_SCALE_INIT;
			S_DIVS, S_DIVX, S_DIVY: cmd.op = OP_DIV_STEP;
			S_COMPX:  cmd.op = OP_COMP_X_INIT;
			S_COMPY:  cmd.op = OP_COMP_Y_INIT;
			S_FINISH: if (status.out_free) cmd.op = zero_q ? OP_RESULT_ZERO : OP_RESULT;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: rtl/core/srd_datapath.sv
// srd_datapath: shared multiplier, bit-serial root, restoring divider,
// stick position store and result register. Uses srd_pkg.
module srd_datapath #(
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srd_pkg::cmd_t        cmd,
	output srd_pkg::status_t     status,
	input  srd_pkg::sample_word_t sample,
	input  logic [srd_pkg::DZ_W-1:0] dz,
	output logic                 result_valid,
	input  logic                 result_ready,
	output srd_pkg::result_word_t result
);
	import srd_pkg::*;

	localparam int NUM_W  = (2*FRAC_BITS+1 > FRAC_BITS+16) ? 2*FRAC_BITS+1 : FRAC_BITS+16;
	localparam int DEN_W  = (FRAC_BITS+1 > 16) ? FRAC_BITS+1 : 16;
	localparam int PROD_W = DEN_W + 16;
	localparam int ONE    = 1 << FRAC_BITS;

	// sample magnitudes and signs
	logic              sel_q;
	logic              neg_x_q, neg_y_q;
	logic [15:0]       mag_x_q, mag_y_q;
	// root
	logic [31:0]       rad_q;
	logic [16:0]       rrem_q;
	logic [15:0]       len_q;
	// divider
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  drem_q;
	logic [FRAC_BITS:0] scale_q;
	logic signed [15:0] px_q;
	// store
	logic signed [15:0] pos_x_q [2];
	logic signed [15:0] pos_y_q [2];
	logic              out_valid_q;
	result_word_t      out_q;

	logic [15:0]       raw_x_u, raw_y_u;
	logic [DEN_W-1:0]  mul_a;
	logic [15:0]       mul_b;
	logic [PROD_W-1:0] prod;
	logic [18:0]       root_sh, root_trial;
	logic              root_ge;
	logic [DEN_W:0]    div_sh;
	logic              div_ge;
	logic [DEN_W-1:0]  len_e, dz_e, one_e, lc, diff;
	logic [15:0]       q16;
	logic signed [15:0] comp_q;
	logic signed [15:0] new_x, new_y, left_x, left_y;
	logic signed [16:0] d_lr, s_lr;
	logic              nz, dneg, sneg, out_free;

	assign raw_x_u = sample.raw_x;
	assign raw_y_u = sample.raw_y;

	always_comb begin
		mul_a = DEN_W'(mag_x_q);
		mul_b = mag_x_q;
		case (cmd.op)
			OP_SQY: begin
				mul_a = DEN_W'(mag_y_q);
				mul_b = mag_y_q;
			end
			OP_COMP_X_INIT: begin
				mul_a = DEN_W'(num_q[FRAC_BITS:0]);
				mul_b = mag_x_q;
			end
			OP_COMP_Y_INIT: begin
				mul_a = DEN_W'(scale_q);
				mul_b = mag_y_q;
			end
			default: ;
		endcase
	end
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign root_sh    = {rrem_q, rad_q[31:30]};
	assign root_trial = {1'b0, len_q, 2'b01};
	assign root_ge    = (root_sh >= root_trial);

	assign div_sh = {drem_q, num_q[NUM_W-1]};
	assign div_ge = (div_sh >= {1'b0, den_q});

	assign len_e = DEN_W'(len_q);
	assign dz_e  = DEN_W'(dz);
	assign one_e = DEN_W'(ONE);
	assign lc    = (len_e > one_e) ? one_e : len_e;
	assign diff  = lc - dz_e;

	assign status.zero     = !((len_e > dz_e) && (dz_e < one_e));
	assign out_free        = !out_valid_q || result_ready;
	assign status.out_free = out_free;

	// quotient to signed component
	assign q16 = num_q[15:0];
	always_comb begin
		comp_q = (cmd.op == OP_COMP_Y_INIT) ?
			(neg_x_q ? $signed(~q16 + 16'd1) : $signed(q16)) :
			(neg_y_q ? $signed(~q16 + 16'd1) : $signed(q16));
	end

	always_comb begin
		new_x = (cmd.op == OP_RESULT) ? px_q : 16'sd0;
		new_y = (cmd.op == OP_RESULT) ? comp_q : 16'sd0;
		left_x = sel_q ? new_x : pos_x_q[1];
		left_y = sel_q ? new_y : pos_y_q[1];
		d_lr = {left_x[15], left_x} - {left_y[15], left_y};
		s_lr = {left_x[15], left_x} + {left_y[15], left_y};
		dneg = d_lr[16];
		sneg = s_lr[16];
		nz   = (left_x != 16'sd0) || (left_y != 16'sd0);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				sel_q   <= sample.stick_select;
				neg_x_q <= raw_x_u[15];
				neg_y_q <= raw_y_u[15];
				mag_x_q <= raw_x_u[15] ? (~raw_x_u + 16'd1) : raw_x_u;
				mag_y_q <= raw_y_u[15] ? (~raw_y_u + 16'd1) : raw_y_u;
			end
			OP_SQX: rad_q <= prod[31:0];
			OP_SQY: begin
				rad_q  <= rad_q + prod[31:0];
				rrem_q <= '0;
				len_q  <= '0;
			end
			OP_ROOT_STEP: begin
				rad_q <= {rad_q[29:0], 2'b00};
				if (root_ge) begin
					rrem_q <= 17'(root_sh - root_trial);
					len_q  <= {len_q[14:0], 1'b1};
				end else begin
					rrem_q <= root_sh[16:0];
					len_q  <= {len_q[14:0], 1'b0};
				end
			end
			OP_SCALE_INIT: begin
				num_q  <= NUM_W'(diff) << FRAC_BITS;
				den_q  <= one_e - dz_e;
				drem_q <= '0;
			end
			OP_DIV_STEP: begin
				num_q  <= {num_q[NUM_W-2:0], div_ge};
				drem_q <= div_ge ? DEN_W'(div_sh - {1'b0, den_q}) : div_sh[DEN_W-1:0];
			end
			OP_COMP_X_INIT: begin
				scale_q <= num_q[FRAC_BITS:0];
				num_q   <= NUM_W'(prod);
				den_q   <= len_e;
				drem_q  <= '0;
			end
			OP_COMP_Y_INIT: begin
				px_q   <= comp_q;
				num_q  <= NUM_W'(prod);
				drem_q <= '0;
			end
			OP_RESULT, OP_RESULT_ZERO: begin
				out_q.scaled_x  <= new_x;
				out_q.scaled_y  <= new_y;
				out_q.dir_left  <= nz && dneg && sneg;
				out_q.dir_right <= nz && !dneg && !sneg;
				out_q.dir_up    <= nz && dneg && !sneg;
				out_q.dir_down  <= nz && !dneg && sneg;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q[0]  <= '0;
			pos_x_q[1]  <= '0;
			pos_y_q[0]  <= '0;
			pos_y_q[1]  <= '0;
		end else begin
			if (cmd.op == OP_RESULT || cmd.op == OP_RESULT_ZERO) begin
				out_valid_q     <= 1'b1;
				pos_x_q[sel_q]  <= new_x;
				pos_y_q[sel_q]  <= new_y;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: rtl/core/stick_radial_deadzone.sv
// stick_radial_deadzone: top level of the two-stick radial deadzone block.
// Instantiates srd_ctrl and srd_datapath, holds the APB deadzone register.
// Uses srd_pkg.
//
// Usage: raw stick words (select, x, y) enter on sample_valid/sample_ready;
// one conditioned word per sample leaves on result_valid/result_ready,
// carrying the new position of the addressed stick and the direction flags
// of the stored left stick.
// One sample is in flight at a time. Outside the deadzone it runs three
// divisions (scale, x, y) through the one-bit-per-cycle restoring divider,
// whose bit count is NUM_W = max(2*FRAC_BITS+1, FRAC_BITS+16); inside the
// deadzone the divisions are skipped. The 16-step root and the divider set
// the time a sample takes. sample_ready rises the cycle after the result
// is loaded, so a waiting result word does not keep the next sample out;
// that sample then holds in its last step until the word has left,
// stalling the input.
// Reset clears both stored positions to zero, empties the result register
// and sets the deadzone to 3277 (0.2). The deadzone is at APB address 0.
module stick_radial_deadzone #(
	parameter int FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  srd_pkg::sample_word_t         sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output srd_pkg::result_word_t         result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import srd_pkg::*;

	logic [DZ_W-1:0] dz_q;
	cmd_t            cmd;
	status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
		end else if (psel && penable && pwrite) begin
			dz_q <= pwdata[DZ_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DEADZONE) ? {(32 - DZ_W)'(0), dz_q} : '0;

	srd_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	srd_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.dz           (dz_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: test/stick_radial_deadzone_tb.sv
`timescale 1ns / 100ps
// stick_radial_deadzone_tb: self-checking bench for the two-stick radial deadzone block.
// Predicts each result word with its own fixed-point model; needs srd_pkg and the RTL.
module stick_radial_deadzone_tb;
	import srd_pkg::*;

	localparam int FRAC_BITS = 14;
	localparam longint UNIT = longint'(1) << FRAC_BITS;
	localparam logic [APB_ADDR_W-1:0] REG_DEADZONE = '0;
	localparam logic APB_READ = 1'b0;
	localparam logic APB_WRITE = 1'b1;
	localparam int HOLD_CYCLES = 900;
	localparam int SETTLE_CYCLES = 160;
	localparam int PHASE_WORDS = 270;

	typedef enum logic {STICK_RIGHT = 1'b0, STICK_LEFT = 1'b1} stick_e;
	typedef enum int {SHAPE_WIDE, SHAPE_REACH, SHAPE_SMALL, SHAPE_EDGE, SHAPE_AXIS} shape_e;

	typedef struct {
		sample_word_t word;
		int unsigned  gap;
	} queued_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_word_t          sample = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_word_t          result;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	queued_sample_t  samples_to_send[$];
	result_word_t    expected_results[$];
	queued_sample_t  next_sample;
	logic [DZ_W-1:0] deadzone = DZ_RESET;
	logic signed [15:0] pos_x [2] = '{16'sd0, 16'sd0};
	logic signed [15:0] pos_y [2] = '{16'sd0, 16'sd0};

	int error_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int settings_used = 1;
	int tx_waited = 0;
	int rx_wait = 0;
	int rx_hold = 0;
	int rx_stall_max = 9;
	int hold_reqs = 0;
	int holds_taken = 0;

	stick_radial_deadzone #(.FRAC_BITS(FRAC_BITS)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#12_000_000;
		$display("stick_radial_deadzone_tb: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic longint root_floor(input longint v);
		longint r;
		longint t;
		r = 0;
		for (int i = 15; i >= 0; i--) begin
			t = r + (longint'(1) << i);
			if (t * t <= v) begin
				r = t;
			end
		end
		return r;
	endfunction

	// component times scale over length, truncated toward zero
	function automatic logic signed [15:0] shrink(input longint c, input longint scale,
			input longint len);
		longint q;
		q = (scale * (c < 0 ? -c : c)) / len;
		return 16'(c < 0 ? -q : q);
	endfunction

	function automatic result_word_t predict_result(input sample_word_t s);
		longint x, y, len, lc, scale, dz, dif, sum;
		logic signed [15:0] px, py;
		logic moved;
		result_word_t r;
		x = s.raw_x;
		y = s.raw_y;
		dz = deadzone;
		len = root_floor(x * x + y * y);
		px = '0;
		py = '0;
		if (len > dz && dz < UNIT) begin
			lc = len > UNIT ? UNIT : len;
			scale = (lc - dz) * UNIT / (UNIT - dz);
			px = shrink(x, scale, len);
			py = shrink(y, scale, len);
		end
		pos_x[s.stick_select] = px;
		pos_y[s.stick_select] = py;
		dif = longint'(pos_x[STICK_LEFT]) - longint'(pos_y[STICK_LEFT]);
		sum = longint'(pos_x[STICK_LEFT]) + longint'(pos_y[STICK_LEFT]);
		moved = pos_x[STICK_LEFT] != 0 || pos_y[STICK_LEFT] != 0;
		r.scaled_x = px;
		r.scaled_y = py;
		r.dir_left = moved && dif < 0 && sum < 0;
		r.dir_right = moved && dif >= 0 && sum >= 0;
		r.dir_up = moved && dif < 0 && sum >= 0;
		r.dir_down = moved && dif >= 0 && sum < 0;
		return r;
	endfunction

	task automatic check_result(input result_word_t got);
		result_word_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result word %p with none pending", got));
			return;
		end
		want = expected_results.pop_front();
		if (got.scaled_x !== want.scaled_x)
			report_mismatch($sformatf("word %0d scaled_x got %0d want %0d",
				results_checked, got.scaled_x, want.scaled_x));
		if (got.scaled_y !== want.scaled_y)
			report_mismatch($sformatf("word %0d scaled_y got %0d want %0d",
				results_checked, got.scaled_y, want.scaled_y));
		if (got.dir_left !== want.dir_left)
			report_mismatch($sformatf("word %0d dir_left got %b want %b",
				results_checked, got.dir_left, want.dir_left));
		if (got.dir_right !== want.dir_right)
			report_mismatch($sformatf("word %0d dir_right got %b want %b",
				results_checked, got.dir_right, want.dir_right));
		if (got.dir_up !== want.dir_up)
			report_mismatch($sformatf("word %0d dir_up got %b want %b",
				results_checked, got.dir_up, want.dir_up));
		if (got.dir_down !== want.dir_down)
			report_mismatch($sformatf("word %0d dir_down got %b want %b",
				results_checked, got.dir_down, want.dir_down));
		results_checked++;
	endtask

	// sample side: each word waits its drawn gap once the channel is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			tx_waited = 0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_results.push_back(predict_result(sample));
				samples_sent++;
			end
			if (!sample_valid || sample_ready) begin
				if (samples_to_send.size() == 0) begin
					sample_valid <= 1'b0;
				end else if (tx_waited < samples_to_send[0].gap) begin
					tx_waited++;
					sample_valid <= 1'b0;
				end else begin
					next_sample = samples_to_send.pop_front();
					sample <= next_sample.word;
					sample_valid <= 1'b1;
					tx_waited = 0;
				end
			end
		end
	end

	// result side: random stall per word, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait = 0;
			rx_hold = 0;
		end else begin
			if (result_valid && result_ready) begin
				check_result(result);
				rx_wait = $urandom_range(0, rx_stall_max);
			end
			if (hold_reqs != holds_taken) begin
				holds_taken = hold_reqs;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				result_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic queue_sample(input stick_e stick, input int x, input int y,
			input int unsigned gap);
		queued_sample_t q;
		q.word.stick_select = stick;
		q.word.raw_x = 16'(x);
		q.word.raw_y = 16'(y);
		q.gap = gap;
		samples_to_send.push_back(q);
	endtask

	function automatic int rand_comp(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	task automatic queue_random(input int n, input int unsigned gap_max);
		shape_e shape;
		int x, y;
		for (int i = 0; i < n; i++) begin
			shape = shape_e'($urandom_range(0, 4));
			case (shape)
				SHAPE_WIDE: begin
					x = $urandom_range(0, 65535);
					y = $urandom_range(0, 65535);
				end
				SHAPE_REACH: begin
					x = rand_comp(24576);
					y = rand_comp(24576);
				end
				SHAPE_SMALL: begin
					x = rand_comp(4096);
					y = rand_comp(4096);
				end
				SHAPE_EDGE: begin
					x = rand_comp(int'(deadzone) + 96);
					y = rand_comp(int'(deadzone) + 96);
				end
				default: begin
					x = $urandom_range(0, 1) ? -32768 : 32767;
					if ($urandom_range(0, 1)) x = rand_comp(32767);
					y = 0;
					if ($urandom_range(0, 1)) begin
						y = x;
						x = 0;
					end
				end
			endcase
			queue_sample(stick_e'($urandom_range(0, 1)), x, y, $urandom_range(0, gap_max));
		end
	endtask

	task automatic wait_idle();
		while (samples_to_send.size() != 0 || sample_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_DEADZONE;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_deadzone(input logic [DZ_W-1:0] v);
		logic [31:0] rd;
		wait_idle();
		repeat (4) @(negedge clk);
		apb_access(APB_WRITE, {{(32 - DZ_W){1'b0}}, v}, rd);
		deadzone = v;
		settings_used++;
		apb_access(APB_READ, '0, rd);
		if (rd[DZ_W-1:0] !== v)
			report_mismatch($sformatf("deadzone read %0d after writing %0d", rd[DZ_W-1:0], v));
	endtask

	initial begin
		logic [31:0] rd;
		int base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_access(APB_READ, '0, rd);
		if (rd[DZ_W-1:0] !== DZ_RESET)
			report_mismatch($sformatf("deadzone after reset %0d", rd[DZ_W-1:0]));

		// reset deadzone: boundary, truncation to nothing, extremes, each direction
		queue_sample(STICK_LEFT, 0, 0, 0);
		queue_sample(STICK_LEFT, 3277, 0, 0);
		queue_sample(STICK_LEFT, 3278, 0, 0);
		queue_sample(STICK_LEFT, 2318, 2318, 0);
		queue_sample(STICK_LEFT, 32767, 32767, 3);
		queue_sample(STICK_LEFT, -32768, -32768, 0);
		queue_sample(STICK_LEFT, 32767, -32768, 0);
		queue_sample(STICK_LEFT, -32768, 32767, 1);
		queue_sample(STICK_LEFT, 16384, 0, 0);
		queue_sample(STICK_LEFT, -16384, 0, 0);
		queue_sample(STICK_LEFT, 0, 16384, 0);
		queue_sample(STICK_LEFT, 0, -16384, 2);
		queue_sample(STICK_LEFT, 8000, 8000, 0);
		queue_sample(STICK_LEFT, -8000, 8000, 0);
		queue_sample(STICK_RIGHT, -32768, 0, 0);
		queue_sample(STICK_RIGHT, 0, 32767, 0);
		queue_sample(STICK_RIGHT, 0, 0, 0);
		queue_sample(STICK_LEFT, 1, -1, 0);

		set_deadzone('0);
		queue_sample(STICK_LEFT, 1, 0, 0);
		queue_sample(STICK_LEFT, 0, 0, 0);
		queue_sample(STICK_RIGHT, -1, -1, 0);
		queue_sample(STICK_LEFT, -32768, -32768, 0);

		set_deadzone(14'd16383);
		queue_sample(STICK_LEFT, 16383, 0, 0);
		queue_sample(STICK_LEFT, 16384, 0, 0);
		queue_sample(STICK_LEFT, 32767, 0, 0);
		queue_sample(STICK_RIGHT, -32768, -32768, 0);

		set_deadzone(DZ_RESET);
		queue_random(PHASE_WORDS, 9);

		set_deadzone('0);
		rx_stall_max <= 0;
		queue_random(PHASE_WORDS, 0);

		// receiver holds off while words keep coming
		set_deadzone(14'd16383);
		rx_stall_max <= 9;
		base = results_checked;
		queue_random(PHASE_WORDS, 9);
		while (results_checked < base + 20) @(negedge clk);
		hold_reqs <= hold_reqs + 1;

		set_deadzone(14'($urandom_range(1, 16382)));
		queue_random(PHASE_WORDS / 2, 0);
		wait_idle();
		queue_random(PHASE_WORDS / 2, 9);

		set_deadzone(14'd1);
		rx_stall_max <= 3;
		queue_random(PHASE_WORDS, 4);

		set_deadzone(14'($urandom_range(1, 16382)));
		rx_stall_max <= 9;
		queue_random(PHASE_WORDS, 9);

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));

		$display("stick_radial_deadzone_tb: %0d samples sent, %0d result words compared",
			samples_sent, results_checked);
		$display("stick_radial_deadzone_tb: %0d deadzone settings, %0d mismatches",
			settings_used, error_count);
		if (error_count == 0) begin
			$display("stick_radial_deadzone_tb: done, clean");
		end else begin
			$display("stick_radial_deadzone_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: stick_radial_deadzone.f
rtl/core/srd_pkg.sv
rtl/core/srd_ctrl.sv
rtl/core/srd_datapath.sv
rtl/core/stick_radial_deadzone.sv
test/stick_radial_deadzone_tb.sv
